// ===== design/assert_macros.svh =====
// Assertion macros used by the cover engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cover engine assertion failed (same cycle)");

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cover engine assertion failed (next cycle)");

`endif

// ===== design/cce_pkg.sv =====
// Shared types and constants of the concept closure cover engine.
`default_nettype none

package cce_pkg;

  // Store geometry and field widths.
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = $clog2(STORE_DEPTH + 1);
  localparam int SET_W       = 64;
  localparam int POP_LEVELS  = $clog2(SET_W);
  localparam int COUNT_W     = 7;
  localparam int CELL_W      = 13;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  // Capacity limits applied to the count registers.
  localparam int MAX_OBJECTS    = 64;
  localparam int MAX_ATTRIBUTES = 64;
  localparam int ROW_CAP = (MAX_OBJECTS < STORE_DEPTH) ? MAX_OBJECTS : STORE_DEPTH;
  localparam int COL_CAP = (MAX_ATTRIBUTES < SET_W) ? MAX_ATTRIBUTES : SET_W;

  // Operation codes.
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_MEET  = 2'd1;
  localparam op_t OP_ATTR  = 2'd2;
  localparam op_t OP_CLEAR = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  // Datapath actions selected by the microcode.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ACCEPT,
    ACT_CLEAR,
    ACT_TOTAL_SUB,
    ACT_LOAD_READ,
    ACT_LOAD_COUNT,
    ACT_LOAD_WRITE,
    ACT_MEET,
    ACT_MEET_FIX,
    ACT_EXTENT,
    ACT_SIZES,
    ACT_FINISH
  } act_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    act_t act;
  } ctrl_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic op_load;
    logic op_meet;
    logic op_attr;
    logic sweep_busy;
    logic out_blocked;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/concept_closure_cover_engine_core.sv =====
// Top level of the concept closure cover engine.
`default_nettype none

// Concept closure cover engine. It holds a 64 by 64 binary relation and an
// uncovered copy of it, and runs one transaction at a time under a microcoded
// sequencer that sweeps the stores one row per cycle through a single read
// port. A concept from attributes and a rectangle removal each make one sweep
// of the 64 rows; a concept from objects makes two sweeps (common attributes,
// then the extent). The next transaction can be accepted in the cycle in which
// a result appears, and a finished result waits in the output register while
// that transaction is worked on; a later result that finds the output register
// still stalled holds the sequencer until it drains. Rows never loaded read as
// zero through per-row valid bits cleared at reset, so no clearing pass is
// needed.
module concept_closure_cover_engine_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [cce_pkg::OP_W-1:0]            op,
  input  logic [cce_pkg::ADDR_W-1:0]          row_index,
  input  logic [cce_pkg::SET_W-1:0]           row_bits,
  input  logic [cce_pkg::SET_W-1:0]           object_set,
  input  logic [cce_pkg::SET_W-1:0]           attribute_set,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [cce_pkg::SET_W-1:0]           extent,
  output logic [cce_pkg::SET_W-1:0]           intent,
  output logic [cce_pkg::COUNT_W-1:0]         extent_ones,
  output logic [cce_pkg::COUNT_W-1:0]         intent_ones,
  output logic [cce_pkg::CELL_W-1:0]          cell_count,
  output logic [cce_pkg::CELL_W-1:0]          uncovered_left,
  input  logic                                cfg_write,
  input  logic [cce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cce_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import cce_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  // Microcode sequencer.
  cce_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .ctrl     (ctrl),
    .in_stall (in_stall)
  );

  // Stores and datapath.
  cce_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .in_valid       (in_valid),
    .op             (op),
    .row_index      (row_index),
    .row_bits       (row_bits),
    .object_set     (object_set),
    .attribute_set  (attribute_set),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .extent         (extent),
    .intent         (intent),
    .extent_ones    (extent_ones),
    .intent_ones    (intent_ones),
    .cell_count     (cell_count),
    .uncovered_left (uncovered_left),
    .stat           (stat)
  );

endmodule

`default_nettype wire

// ===== design/cce_seq.sv =====
// Microcode sequencer: step counter and control store of the cover engine.
`default_nettype none

module cce_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  cce_pkg::stat_t stat,
  output cce_pkg::ctrl_t ctrl,
  output logic          in_stall
);
  import cce_pkg::*;

  localparam int PC_W = 4;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_OP_LOAD,
    COND_OP_MEET,
    COND_OP_ATTR,
    COND_SWEEP_BUSY,
    COND_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    act_t             act;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  // Step addresses of the program.
  localparam logic [PC_W-1:0] ST_WAIT       = 4'd0;
  localparam logic [PC_W-1:0] ST_IS_LOAD    = 4'd1;
  localparam logic [PC_W-1:0] ST_IS_MEET    = 4'd2;
  localparam logic [PC_W-1:0] ST_IS_ATTR    = 4'd3;
  localparam logic [PC_W-1:0] ST_CLEAR      = 4'd4;
  localparam logic [PC_W-1:0] ST_TOTAL_SUB  = 4'd5;
  localparam logic [PC_W-1:0] ST_LOAD_READ  = 4'd6;
  localparam logic [PC_W-1:0] ST_LOAD_COUNT = 4'd7;
  localparam logic [PC_W-1:0] ST_LOAD_WRITE = 4'd8;
  localparam logic [PC_W-1:0] ST_MEET       = 4'd9;
  localparam logic [PC_W-1:0] ST_MEET_FIX   = 4'd10;
  localparam logic [PC_W-1:0] ST_EXTENT     = 4'd11;
  localparam logic [PC_W-1:0] ST_SIZES      = 4'd12;
  localparam logic [PC_W-1:0] ST_OUT_WAIT   = 4'd13;
  localparam logic [PC_W-1:0] ST_FINISH     = 4'd14;

  // Control store. A step jumps to its target when its condition holds,
  // otherwise it falls through to the next step.
  function automatic uword_t rom(input logic [PC_W-1:0] a);
    uword_t w;
    case (a)
      ST_WAIT:       w = '{ACT_ACCEPT,     COND_NO_ITEM,     ST_WAIT};
      ST_IS_LOAD:    w = '{ACT_NONE,       COND_OP_LOAD,     ST_LOAD_READ};
      ST_IS_MEET:    w = '{ACT_NONE,       COND_OP_MEET,     ST_MEET};
      ST_IS_ATTR:    w = '{ACT_NONE,       COND_OP_ATTR,     ST_EXTENT};
      ST_CLEAR:      w = '{ACT_CLEAR,      COND_SWEEP_BUSY,  ST_CLEAR};
      ST_TOTAL_SUB:  w = '{ACT_TOTAL_SUB,  COND_ALWAYS,      ST_SIZES};
      ST_LOAD_READ:  w = '{ACT_LOAD_READ,  COND_NEXT,        ST_WAIT};
      ST_LOAD_COUNT: w = '{ACT_LOAD_COUNT, COND_NEXT,        ST_WAIT};
      ST_LOAD_WRITE: w = '{ACT_LOAD_WRITE, COND_ALWAYS,      ST_SIZES};
      ST_MEET:       w = '{ACT_MEET,       COND_SWEEP_BUSY,  ST_MEET};
      ST_MEET_FIX:   w = '{ACT_MEET_FIX,   COND_NEXT,        ST_WAIT};
      ST_EXTENT:     w = '{ACT_EXTENT,     COND_SWEEP_BUSY,  ST_EXTENT};
      ST_SIZES:      w = '{ACT_SIZES,      COND_NEXT,        ST_WAIT};
      ST_OUT_WAIT:   w = '{ACT_NONE,       COND_OUT_BLOCKED, ST_OUT_WAIT};
      ST_FINISH:     w = '{ACT_FINISH,     COND_ALWAYS,      ST_WAIT};
      default:       w = '{ACT_NONE,       COND_ALWAYS,      ST_WAIT};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  uword_t          word;
  logic            take;

  // Current control word and its jump condition.
  always_comb begin
    word = rom(pc);
    case (word.cond)
      COND_NEXT:        take = 1'b0;
      COND_ALWAYS:      take = 1'b1;
      COND_NO_ITEM:     take = !in_valid;
      COND_OP_LOAD:     take = stat.op_load;
      COND_OP_MEET:     take = stat.op_meet;
      COND_OP_ATTR:     take = stat.op_attr;
      COND_SWEEP_BUSY:  take = stat.sweep_busy;
      COND_OUT_BLOCKED: take = stat.out_blocked;
      default:          take = 1'b0;
    endcase
    pc_next  = take ? word.target : pc + 1'b1;
    ctrl.act = word.act;
    in_stall = (word.act != ACT_ACCEPT);
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/cce_dp.sv =====
// Datapath of the cover engine: relation stores, sweep pipeline and result register.
`default_nettype none
`include "assert_macros.svh"

module cce_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  cce_pkg::ctrl_t                      ctrl,
  input  logic                                in_valid,
  input  logic [cce_pkg::OP_W-1:0]            op,
  input  logic [cce_pkg::ADDR_W-1:0]          row_index,
  input  logic [cce_pkg::SET_W-1:0]           row_bits,
  input  logic [cce_pkg::SET_W-1:0]           object_set,
  input  logic [cce_pkg::SET_W-1:0]           attribute_set,
  input  logic                                cfg_write,
  input  logic [cce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cce_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [cce_pkg::SET_W-1:0]           extent,
  output logic [cce_pkg::SET_W-1:0]           intent,
  output logic [cce_pkg::COUNT_W-1:0]         extent_ones,
  output logic [cce_pkg::COUNT_W-1:0]         intent_ones,
  output logic [cce_pkg::CELL_W-1:0]          cell_count,
  output logic [cce_pkg::CELL_W-1:0]          uncovered_left,
  output cce_pkg::stat_t                      stat
);
  import cce_pkg::*;

  // Adder tree population count, one level per halving.
  function automatic logic [COUNT_W-1:0] popcount(input logic [SET_W-1:0] v);
    logic [COUNT_W-1:0] s [SET_W];
    for (int k = 0; k < SET_W; k++) s[k] = COUNT_W'(v[k]);
    for (int lvl = 0; lvl < POP_LEVELS; lvl++) begin
      for (int k = 0; k < (SET_W >> (lvl + 1)); k++) s[k] = s[2*k] + s[2*k+1];
    end
    return s[0];
  endfunction

  // Relation and uncovered stores; rows never loaded read as zero.
  logic [SET_W-1:0] rel_mem [STORE_DEPTH];
  logic [SET_W-1:0] unc_mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] row_valid;

  logic [CFG_DATA_W-1:0] rows_in_use;
  logic [CFG_DATA_W-1:0] cols_in_use;
  logic [COUNT_W-1:0]    nrows;
  logic [COUNT_W-1:0]    ncols;
  logic [SET_W-1:0]      rmask;
  logic [SET_W-1:0]      cmask;

  op_t                cur_op;
  logic [ADDR_W-1:0]  row;
  logic [SET_W-1:0]   bits;
  logic [SET_W-1:0]   objs;
  logic [SET_W-1:0]   cur_ext;
  logic [SET_W-1:0]   cur_int;
  logic [CELL_W-1:0]  cells;
  logic [CELL_W-1:0]  total;
  logic [COUNT_W-1:0] pop_old;
  logic [COUNT_W-1:0] pop_new;
  logic [COUNT_W-1:0] ext_size_r;
  logic [COUNT_W-1:0] int_size_r;
  logic [IDX_W-1:0]   idx;

  logic               p1_valid;
  logic [ADDR_W-1:0]  p1_addr;
  logic               p1_ok;
  logic [SET_W-1:0]   rel_q;
  logic [SET_W-1:0]   unc_q;
  logic               p2_valid;
  logic [SET_W-1:0]   p2_word;

  logic               accept;
  logic               sweep_act;
  logic               issue;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic [SET_W-1:0]   rel_eff;
  logic [SET_W-1:0]   unc_eff;
  logic               ext_hit;
  logic               clear_hit;
  logic               row_ok;
  logic               rel_we;
  logic               unc_we;
  logic [ADDR_W-1:0]  unc_waddr;
  logic [SET_W-1:0]   unc_wdata;

  // Effective row and column counts and their masks.
  always_comb begin
    nrows = (rows_in_use > COUNT_W'(ROW_CAP)) ? COUNT_W'(ROW_CAP) : rows_in_use;
    ncols = (cols_in_use > COUNT_W'(COL_CAP)) ? COUNT_W'(COL_CAP) : cols_in_use;
    for (int i = 0; i < SET_W; i++) begin
      rmask[i] = (COUNT_W'(i) < nrows);
      cmask[i] = (COUNT_W'(i) < ncols);
    end
  end

  // Sweep issue, store read and write selection.
  always_comb begin
    accept    = (ctrl.act == ACT_ACCEPT) && in_valid;
    sweep_act = (ctrl.act == ACT_MEET) || (ctrl.act == ACT_EXTENT) ||
                (ctrl.act == ACT_CLEAR);
    issue     = sweep_act && (idx < IDX_W'(STORE_DEPTH));
    rd_en     = issue || (ctrl.act == ACT_LOAD_READ);
    rd_addr   = (ctrl.act == ACT_LOAD_READ) ? row : idx[ADDR_W-1:0];
    rel_eff   = p1_ok ? rel_q : '0;
    unc_eff   = p1_ok ? unc_q : '0;
    ext_hit   = p1_valid && (cur_int != '0) && rmask[p1_addr] &&
                ((rel_eff & cur_int) == cur_int);
    clear_hit = (ctrl.act == ACT_CLEAR) && p1_valid && cur_ext[p1_addr];
    row_ok    = ({1'b0, row} < nrows);
    rel_we    = (ctrl.act == ACT_LOAD_WRITE) && row_ok;
    unc_we    = rel_we || clear_hit;
    unc_waddr = rel_we ? row : p1_addr;
    unc_wdata = rel_we ? bits : (unc_eff & ~cur_int);
  end

  // Store ports: one registered read, one write per store.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rel_q <= rel_mem[rd_addr];
      unc_q <= unc_mem[rd_addr];
    end
    if (rel_we) begin
      rel_mem[row] <= bits;
    end
    if (unc_we) begin
      unc_mem[unc_waddr] <= unc_wdata;
    end
  end

  // Control state: configuration, totals, valid bits, sweep and output flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= CFG_DATA_W'(STORE_DEPTH);
      cols_in_use <= CFG_DATA_W'(SET_W);
      total       <= '0;
      row_valid   <= '0;
      idx         <= '0;
      p1_valid    <= 1'b0;
      p2_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ROWS_IN_USE: rows_in_use <= cfg_data;
          REG_COLS_IN_USE: cols_in_use <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      p1_valid <= issue;
      p2_valid <= p1_valid && ((ctrl.act == ACT_EXTENT) || (ctrl.act == ACT_CLEAR));
      if (issue) begin
        idx <= idx + 1'b1;
      end
      case (ctrl.act)
        ACT_ACCEPT: begin
          if (in_valid) idx <= '0;
        end
        ACT_MEET_FIX: idx <= '0;
        ACT_LOAD_WRITE: begin
          if (row_ok) begin
            row_valid[row] <= 1'b1;
            total <= total - CELL_W'(pop_old) + CELL_W'(pop_new);
          end
        end
        ACT_TOTAL_SUB: total <= total - cells;
        ACT_FINISH:    out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload: item fields, sweep pipeline, accumulators and result fields.
  always_ff @(posedge clk) begin
    p1_addr <= rd_addr;
    p1_ok   <= row_valid[rd_addr];
    if (p2_valid) begin
      cells <= cells + CELL_W'(popcount(p2_word));
    end
    case (ctrl.act)
      ACT_ACCEPT: begin
        if (accept) begin
          cur_op <= op;
          row    <= row_index;
          bits   <= row_bits & cmask;
          objs   <= object_set & rmask;
          cells  <= '0;
          case (op)
            OP_LOAD:  cur_int <= '0;
            OP_MEET:  cur_int <= '1;
            default:  cur_int <= attribute_set & cmask;
          endcase
          cur_ext <= (op == OP_CLEAR) ? (object_set & rmask) : '0;
        end
      end
      ACT_MEET: begin
        if (p1_valid && objs[p1_addr]) cur_int <= cur_int & rel_eff;
      end
      ACT_MEET_FIX: cur_int <= (objs != '0) ? (cur_int & cmask) : '0;
      ACT_EXTENT: begin
        if (ext_hit) cur_ext[p1_addr] <= 1'b1;
        p2_word <= ext_hit ? (unc_eff & cur_int) : '0;
      end
      ACT_CLEAR: p2_word <= clear_hit ? (unc_eff & cur_int) : '0;
      ACT_LOAD_COUNT: begin
        pop_old <= popcount(unc_eff);
        pop_new <= popcount(bits);
      end
      ACT_SIZES: begin
        ext_size_r <= popcount(cur_ext);
        int_size_r <= popcount(cur_int);
      end
      ACT_FINISH: begin
        extent         <= cur_ext;
        intent         <= cur_int;
        extent_ones    <= ext_size_r;
        intent_ones    <= int_size_r;
        cell_count     <= cells;
        uncovered_left <= total;
      end
      default: ;
    endcase
  end

  // Status toward the sequencer.
  always_comb begin
    stat.op_load     = (cur_op == OP_LOAD);
    stat.op_meet     = (cur_op == OP_MEET);
    stat.op_attr     = (cur_op == OP_ATTR);
    stat.sweep_busy  = (idx < IDX_W'(STORE_DEPTH)) || p1_valid || p2_valid;
    stat.out_blocked = out_valid && out_stall;
  end

  // The uncovered count can never exceed the size of the store.
  `ASSERT_IMPLIES(a_total_range, clk, rst, 1'b1, total <= CELL_W'(STORE_DEPTH * SET_W))
  // Result sizes agree with the result sets.
  `ASSERT_IMPLIES(a_extent_ones, clk, rst, out_valid, extent_ones == COUNT_W'($countones(extent)))
  `ASSERT_IMPLIES(a_intent_ones, clk, rst, out_valid, intent_ones == COUNT_W'($countones(intent)))
  // A load into a row in range marks that row valid.
  `ASSERT_NEXT(a_load_marks_row, clk, rst, rel_we, row_valid[$past(row)])
  // The popcount stage only ever follows a read stage.
  `ASSERT_IMPLIES(a_p2_after_p1, clk, rst, p2_valid, $past(p1_valid))

endmodule

`default_nettype wire
